FILE: rtl/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at the same edge as the trigger
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition holds at the next edge after the trigger
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/bcla_pkg.sv
package bcla_pkg;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_DELAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_PER   = 2'd3;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] BOUNCE_RST     = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LONG_RST       = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] AUTO_DELAY_RST = 16'd0;
  localparam logic [CFG_DATA_W-1:0] AUTO_PER_RST   = 16'd500;

  // reported events
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2,
    EV_AUTO  = 2'd3
  } event_e;

  // timing configuration
  typedef struct packed {
    logic [CFG_DATA_W-1:0] bounce_ms;
    logic [CFG_DATA_W-1:0] long_ms;
    logic [CFG_DATA_W-1:0] auto_delay_ms;
    logic [CFG_DATA_W-1:0] auto_period_ms;
  } cfg_t;

  // controls from the pipeline to the evaluation core
  typedef struct packed {
    logic fire;
  } core_ctrl_t;

endpackage

FILE: rtl/bcla_core.sv
module bcla_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bcla_pkg::core_ctrl_t           ctrl_i,
  input  bcla_pkg::cfg_t                 cfg_i,
  input  logic                           pin_level_i,
  input  logic [bcla_pkg::TIME_W-1:0]    now_ms_i,
  output bcla_pkg::event_e               event_o
);

  logic                        pressed_q, pressed_d;
  logic                        long_fired_q, long_fired_d;
  logic                        auto_fired_q, auto_fired_d;
  logic [bcla_pkg::TIME_W-1:0] release_q, release_d;
  logic [bcla_pkg::TIME_W-1:0] press_q, press_d;
  logic [bcla_pkg::TIME_W-1:0] last_auto_q, last_auto_d;

  logic                        low;
  logic                        features;
  logic [bcla_pkg::TIME_W-1:0] since_release, since_press, since_auto;
  logic [bcla_pkg::TIME_W-1:0] bounce_w, long_w, delay_w, period_w;
  logic                        press_hit, long_hit, auto_hit, release_hit;

  // elapsed times, wrapping
  always_comb begin
    low           = ~pin_level_i;
    features      = (|cfg_i.long_ms) | (|cfg_i.auto_delay_ms);
    since_release = now_ms_i - release_q;
    since_press   = now_ms_i - press_q;
    since_auto    = now_ms_i - last_auto_q;
    bounce_w      = {{(bcla_pkg::TIME_W-bcla_pkg::CFG_DATA_W){1'b0}}, cfg_i.bounce_ms};
    long_w        = {{(bcla_pkg::TIME_W-bcla_pkg::CFG_DATA_W){1'b0}}, cfg_i.long_ms};
    delay_w       = {{(bcla_pkg::TIME_W-bcla_pkg::CFG_DATA_W){1'b0}}, cfg_i.auto_delay_ms};
    period_w      = {{(bcla_pkg::TIME_W-bcla_pkg::CFG_DATA_W){1'b0}}, cfg_i.auto_period_ms};
  end

  // the four checks
  always_comb begin
    press_hit   = low & ~pressed_q & (since_release > bounce_w);
    long_hit    = low & ~long_fired_q & (|cfg_i.long_ms) & (since_press > long_w);
    auto_hit    = low & (|cfg_i.auto_delay_ms) & (since_press > delay_w) &
                  (since_auto > period_w);
    release_hit = ~low & pressed_q & (since_press > bounce_w);
  end

  // first matching check decides; a fresh press leaves zero hold time,
  // so long and auto cannot follow it in the same transaction
  always_comb begin
    pressed_d    = pressed_q;
    long_fired_d = long_fired_q;
    auto_fired_d = auto_fired_q;
    release_d    = release_q;
    press_d      = press_q;
    last_auto_d  = last_auto_q;
    event_o      = bcla_pkg::EV_NONE;
    priority if (press_hit) begin
      pressed_d    = 1'b1;
      long_fired_d = 1'b0;
      auto_fired_d = 1'b0;
      press_d      = now_ms_i;
      event_o      = features ? bcla_pkg::EV_NONE : bcla_pkg::EV_CLICK;
    end else if (long_hit) begin
      long_fired_d = 1'b1;
      event_o      = bcla_pkg::EV_LONG;
    end else if (auto_hit) begin
      auto_fired_d = 1'b1;
      last_auto_d  = now_ms_i;
      event_o      = bcla_pkg::EV_AUTO;
    end else if (release_hit) begin
      pressed_d = 1'b0;
      release_d = now_ms_i;
      if (features && !long_fired_q && !auto_fired_q) begin
        event_o = bcla_pkg::EV_CLICK;
      end
    end else begin
      event_o = bcla_pkg::EV_NONE;
    end
  end

  // button state, updated once per evaluated transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q    <= 1'b0;
      long_fired_q <= 1'b0;
      auto_fired_q <= 1'b0;
      release_q    <= '0;
      press_q      <= '0;
      last_auto_q  <= '0;
    end else if (ctrl_i.fire) begin
      pressed_q    <= pressed_d;
      long_fired_q <= long_fired_d;
      auto_fired_q <= auto_fired_d;
      release_q    <= release_d;
      press_q      <= press_d;
      last_auto_q  <= last_auto_d;
    end
  end

endmodule

FILE: rtl/button_click_long_autorepeat.sv
// channel | direction | handshake             | payload
// input   | in        | in_valid_i/in_stall_o  | pin_level_i, now_ms_i
// output  | out       | out_valid_o/out_stall_i| event_res_o
// config  | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle unless the output stalls; a transaction goes
// via the input register and one evaluation pass into the result register
// the rate is set by the state update loop in bcla_core
// reset restores the register defaults and clears all button state
// a stalled result holds the result register; the input register keeps
// accepting until it is also full

`include "assert_macros.svh"

module button_click_long_autorepeat (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                pin_level_i,
  input  logic [bcla_pkg::TIME_W-1:0]         now_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          event_res_o,
  input  logic                                cfg_we_i,
  input  logic [bcla_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bcla_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  bcla_pkg::cfg_t              cfg_q;
  logic                        s1_valid_q;
  logic                        s1_pin_q;
  logic [bcla_pkg::TIME_W-1:0] s1_now_q;
  logic                        out_valid_q;
  logic [1:0]                  out_event_q;
  logic                        out_load;
  logic                        s1_load;
  bcla_pkg::core_ctrl_t        core_ctrl;
  bcla_pkg::event_e            core_event;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bounce_ms      <= bcla_pkg::BOUNCE_RST;
      cfg_q.long_ms        <= bcla_pkg::LONG_RST;
      cfg_q.auto_delay_ms  <= bcla_pkg::AUTO_DELAY_RST;
      cfg_q.auto_period_ms <= bcla_pkg::AUTO_PER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcla_pkg::CFG_BOUNCE:     cfg_q.bounce_ms      <= cfg_wdata_i;
        bcla_pkg::CFG_LONG:       cfg_q.long_ms        <= cfg_wdata_i;
        bcla_pkg::CFG_AUTO_DELAY: cfg_q.auto_delay_ms  <= cfg_wdata_i;
        bcla_pkg::CFG_AUTO_PER:   cfg_q.auto_period_ms <= cfg_wdata_i;
        default:                  cfg_q                <= cfg_q;
      endcase
    end
  end

  // flow control
  always_comb begin
    out_load       = s1_valid_q & (~out_valid_q | ~out_stall_i);
    s1_load        = in_valid_i & ~in_stall_o;
    in_stall_o     = s1_valid_q & ~out_load;
    core_ctrl.fire = out_load;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load || out_load) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_pin_q <= pin_level_i;
      s1_now_q <= now_ms_i;
    end
  end

  // evaluation and button state
  bcla_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (core_ctrl),
    .cfg_i       (cfg_q),
    .pin_level_i (s1_pin_q),
    .now_ms_i    (s1_now_q),
    .event_o     (core_event)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load || !out_stall_i) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_event_q <= core_event;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = out_event_q;

  // checks
  `ASSERT_IMPL(a_result_from_input, clk_i, rst_ni, $rose(out_valid_q), $past(s1_valid_q))
  `ASSERT_NEXT(a_held_while_blocked, clk_i, rst_ni,
               s1_valid_q && out_valid_q && out_stall_i, s1_valid_q)
  `ASSERT_IMPL(a_long_needs_enable, clk_i, rst_ni,
               out_valid_q && (out_event_q == bcla_pkg::EV_LONG), cfg_q.long_ms != '0)
  `ASSERT_IMPL(a_auto_needs_enable, clk_i, rst_ni,
               out_valid_q && (out_event_q == bcla_pkg::EV_AUTO), cfg_q.auto_delay_ms != '0)

endmodule
